### design/cst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg: shared definitions for the character stream tokenizer
// Token kind codes, run modes, character constants and the token record.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Width of the internal column and line counters.
  localparam int POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // Width of a position field in a token.
  localparam int FIELD_BITS = 16;

  typedef logic [POS_BITS-1:0] pos_t;

  // Token kinds.
  localparam logic [3:0] K_NUM    = 4'd0;
  localparam logic [3:0] K_PLUS   = 4'd1;
  localparam logic [3:0] K_MINUS  = 4'd2;
  localparam logic [3:0] K_STAR   = 4'd3;
  localparam logic [3:0] K_SLASH  = 4'd4;
  localparam logic [3:0] K_LPAREN = 4'd5;
  localparam logic [3:0] K_RPAREN = 4'd6;
  localparam logic [3:0] K_EOL    = 4'd7;
  localparam logic [3:0] K_UNEXP  = 4'd8;
  localparam logic [3:0] K_EQUAL  = 4'd9;
  localparam logic [3:0] K_IDENT  = 4'd10;
  localparam logic [3:0] K_EOF    = 4'd11;

  // Pending run modes.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_IDENT = 2'd1;
  localparam logic [1:0] MODE_NUM   = 2'd2;

  // Input item kinds.
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_EOT  = 1'b1;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    logic                  last;
    logic [7:0]            token_char;
    logic [FIELD_BITS-1:0] line_num;
    logic [FIELD_BITS-1:0] end_col;
    logic [FIELD_BITS-1:0] start_col;
    logic [3:0]            token_kind;
  } token_t;

  // Saturating increment of a position counter.
  function automatic pos_t sat_inc(input pos_t v);
    sat_inc = (v == POS_MAX) ? v : v + pos_t'(1);
  endfunction

  // Kind of a single-character token; anything unlisted is unexpected.
  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    unique case (c)
      CH_LPAREN: punct_kind = K_LPAREN;
      CH_RPAREN: punct_kind = K_RPAREN;
      CH_PLUS:   punct_kind = K_PLUS;
      CH_MINUS:  punct_kind = K_MINUS;
      CH_STAR:   punct_kind = K_STAR;
      CH_SLASH:  punct_kind = K_SLASH;
      CH_EQUAL:  punct_kind = K_EQUAL;
      CH_NEWLINE: punct_kind = K_EOL;
      default:   punct_kind = K_UNEXP;
    endcase
  endfunction

endpackage
`default_nettype wire

### design/char_stream_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_stream_tokenizer: streaming lexical scanner
// Turns a byte stream into identifier, number and one-character tokens.
// ----------------------------------------------------------------------------
// The block takes one text byte per transfer on the slave side (tuser low) or
// an end-of-text marker (tuser high), and sends tokens on the master side.
// Letter runs become identifiers, digit runs numbers; ( ) + - * / = and newline
// give one-character tokens, a space is skipped and any other byte gives an
// unexpected token. A run is sent when the first byte that does not continue
// it arrives, so one input transfer can cause zero, one or two tokens; tlast
// marks the last token of an input. End of text sends any pending run, then
// an eof token, and returns all scanner state to reset. The scanner state is updated
// in the cycle an input is accepted, and the tokens go into a four-entry
// result queue. An input is accepted in every cycle while the queue holds two
// or fewer tokens; the queue drains one token per cycle while m_tready is high, so
// inputs that cause two tokens are held back, and all others flow at one per cycle.
// ----------------------------------------------------------------------------
module char_stream_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  // Slave side: text bytes.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tuser,   // [0] func
  // Master side: tokens.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [3:0] token_kind, [19:4] start_col,
                                      // [35:20] end_col, [51:36] line_num,
                                      // [59:52] token_char, [63:60] zero
  output logic             m_tlast    // last_of_run
);

  // Scanner state.
  logic [1:0]     run_mode;
  cst_pkg::pos_t  run_start_col;
  cst_pkg::pos_t  column_count;
  cst_pkg::pos_t  line_count;

  logic [1:0]     run_mode_next;
  cst_pkg::pos_t  run_start_col_next;
  cst_pkg::pos_t  column_count_next;
  cst_pkg::pos_t  line_count_next;

  // Result queue.
  cst_pkg::token_t fifo_mem [4];
  logic [1:0]      wr_ptr;
  logic [1:0]      rd_ptr;
  logic [2:0]      count;

  logic            accept;
  logic            pop;
  logic [1:0]      push_n;

  // Classification of the incoming byte.
  logic            is_letter;
  logic            is_digit;
  logic            is_eot;
  logic            run_pending;
  logic            continues;
  logic            has_run;
  logic            has_new;
  cst_pkg::pos_t   col_inc;
  cst_pkg::token_t run_tok;
  cst_pkg::token_t new_tok;
  cst_pkg::token_t wr_tok0;
  cst_pkg::token_t wr_tok1;

  assign accept = s_tvalid && s_tready;
  assign pop    = m_tvalid && m_tready;

  // Room for the largest burst of two tokens must exist before accepting.
  assign s_tready = (count <= 3'd2);
  assign m_tvalid = (count != 3'd0);

  always_comb begin
    is_letter   = ((s_tdata >= 8'h41) && (s_tdata <= 8'h5A)) ||
                  ((s_tdata >= 8'h61) && (s_tdata <= 8'h7A));
    is_digit    = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);
    is_eot      = (s_tuser == cst_pkg::FUNC_EOT);
    run_pending = (run_mode == cst_pkg::MODE_IDENT) || (run_mode == cst_pkg::MODE_NUM);
    continues   = !is_eot &&
                  (((run_mode == cst_pkg::MODE_IDENT) && is_letter) ||
                   ((run_mode == cst_pkg::MODE_NUM) && is_digit));
    has_run     = run_pending && !continues;
    col_inc     = cst_pkg::sat_inc(column_count);

    // The pending run closes at the current column.
    run_tok.token_kind = (run_mode == cst_pkg::MODE_IDENT) ? cst_pkg::K_IDENT
                                                           : cst_pkg::K_NUM;
    run_tok.start_col  = cst_pkg::FIELD_BITS'(run_start_col);
    run_tok.end_col    = cst_pkg::FIELD_BITS'(column_count);
    run_tok.line_num   = cst_pkg::FIELD_BITS'(line_count);
    run_tok.token_char = 8'd0;
    run_tok.last       = 1'b0;

    // Token of the new byte itself, or the eof token.
    new_tok.start_col  = cst_pkg::FIELD_BITS'(column_count);
    new_tok.line_num   = cst_pkg::FIELD_BITS'(line_count);
    new_tok.last       = 1'b1;
    if (is_eot) begin
      new_tok.token_kind = cst_pkg::K_EOF;
      new_tok.end_col    = cst_pkg::FIELD_BITS'(column_count);
      new_tok.token_char = 8'd0;
    end else begin
      new_tok.token_kind = cst_pkg::punct_kind(s_tdata);
      new_tok.end_col    = cst_pkg::FIELD_BITS'(col_inc);
      new_tok.token_char = s_tdata;
    end

    run_mode_next      = run_mode;
    run_start_col_next = run_start_col;
    column_count_next  = column_count;
    line_count_next    = line_count;
    has_new            = 1'b0;

    priority if (is_eot) begin
      has_new            = 1'b1;
      run_mode_next      = cst_pkg::MODE_IDLE;
      run_start_col_next = '0;
      column_count_next  = '0;
      line_count_next    = '0;
    end else if (continues) begin
      column_count_next = col_inc;
    end else if (s_tdata == cst_pkg::CH_SPACE) begin
      run_mode_next     = cst_pkg::MODE_IDLE;
      column_count_next = col_inc;
    end else if (is_letter || is_digit) begin
      run_mode_next      = is_letter ? cst_pkg::MODE_IDENT : cst_pkg::MODE_NUM;
      run_start_col_next = column_count;
      column_count_next  = col_inc;
    end else if (s_tdata == cst_pkg::CH_NEWLINE) begin
      has_new           = 1'b1;
      run_mode_next     = cst_pkg::MODE_IDLE;
      column_count_next = '0;
      line_count_next   = cst_pkg::sat_inc(line_count);
    end else begin
      has_new           = 1'b1;
      run_mode_next     = cst_pkg::MODE_IDLE;
      column_count_next = col_inc;
    end

    // A closed run goes first; the new token follows it.
    wr_tok0      = has_run ? run_tok : new_tok;
    wr_tok0.last = !(has_run && has_new);
    wr_tok1      = new_tok;
    push_n       = accept ? ({1'b0, has_run} + {1'b0, has_new}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode      <= cst_pkg::MODE_IDLE;
      run_start_col <= '0;
      column_count  <= '0;
      line_count    <= '0;
    end else if (accept) begin
      run_mode      <= run_mode_next;
      run_start_col <= run_start_col_next;
      column_count  <= column_count_next;
      line_count    <= line_count_next;
    end
  end

  // Queue storage carries payload only.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= wr_tok0;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr + 2'd1] <= wr_tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push_n} - {2'b00, pop};
    end
  end

  always_comb begin
    m_tdata = {4'd0,
               fifo_mem[rd_ptr].token_char,
               fifo_mem[rd_ptr].line_num,
               fifo_mem[rd_ptr].end_col,
               fifo_mem[rd_ptr].start_col,
               fifo_mem[rd_ptr].token_kind};
    m_tlast = fifo_mem[rd_ptr].last;
  end

  // The queue never holds more than its four entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue overflow");

  // The pointers stay the fill level apart.
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[1:0])
    else $error("queue pointers disagree with fill level");

  // End of text leaves the scanner in its reset state.
  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && is_eot) |=> (run_mode == cst_pkg::MODE_IDLE) &&
                           (column_count == '0) && (line_count == '0))
    else $error("scanner state not cleared after end of text");

  // A newline always returns the column to zero.
  a_newline_col: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_eot && (s_tdata == cst_pkg::CH_NEWLINE)) |=> (column_count == '0))
    else $error("column not reset after newline");

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for char_stream_tokenizer
// Streams text bytes and end-of-text markers into the scanner while a
// behavioral scanner predicts the token stream. Every token is checked field
// by field against the prediction.
// ----------------------------------------------------------------------------
module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = cst_pkg::FUNC_CHAR;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;

  char_stream_tokenizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Tokens predicted but not yet seen on the master side, oldest first.
  cst_pkg::token_t expected_tokens[$];

  // Scanner state as the prediction sees it.
  logic [1:0]    scan_mode = cst_pkg::MODE_IDLE;
  cst_pkg::pos_t run_col   = '0;
  cst_pkg::pos_t col_pos   = '0;
  cst_pkg::pos_t line_pos  = '0;

  bit idle_on     = 1'b1;
  int hold_req    = 0;
  int err_count   = 0;
  int chars_sent  = 0;
  int tokens_seen = 0;

  function automatic cst_pkg::pos_t bump(input cst_pkg::pos_t v);
    return (v == cst_pkg::POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [3:0] single_kind(input logic [7:0] c);
    case (c)
      cst_pkg::CH_LPAREN: return cst_pkg::K_LPAREN;
      cst_pkg::CH_RPAREN: return cst_pkg::K_RPAREN;
      cst_pkg::CH_PLUS:   return cst_pkg::K_PLUS;
      cst_pkg::CH_MINUS:  return cst_pkg::K_MINUS;
      cst_pkg::CH_STAR:   return cst_pkg::K_STAR;
      cst_pkg::CH_SLASH:  return cst_pkg::K_SLASH;
      cst_pkg::CH_EQUAL:  return cst_pkg::K_EQUAL;
      default:            return cst_pkg::K_UNEXP;
    endcase
  endfunction

  function automatic cst_pkg::token_t make_token(input logic [3:0] kind,
                                                 input cst_pkg::pos_t s,
                                                 input cst_pkg::pos_t e,
                                                 input logic [7:0] c);
    cst_pkg::token_t t;
    t.last       = 1'b0;
    t.token_char = c;
    t.line_num   = line_pos;
    t.end_col    = e;
    t.start_col  = s;
    t.token_kind = kind;
    return t;
  endfunction

  // Advances the predicted scanner by one accepted input and queues the
  // tokens that this input causes.
  function automatic void predict_tokens(input logic func, input logic [7:0] c);
    cst_pkg::token_t toks[$];
    if (func == cst_pkg::FUNC_CHAR &&
        ((scan_mode == cst_pkg::MODE_IDENT && is_alpha(c)) ||
         (scan_mode == cst_pkg::MODE_NUM && is_digit(c)))) begin
      col_pos = bump(col_pos);
      return;
    end
    // The pending run, if any, is closed by this input.
    if (scan_mode == cst_pkg::MODE_IDENT || scan_mode == cst_pkg::MODE_NUM)
      toks.push_back(make_token(scan_mode == cst_pkg::MODE_IDENT ? cst_pkg::K_IDENT
                                                                 : cst_pkg::K_NUM,
                                run_col, col_pos, 8'h00));
    scan_mode = cst_pkg::MODE_IDLE;
    if (func == cst_pkg::FUNC_EOT) begin
      toks.push_back(make_token(cst_pkg::K_EOF, col_pos, col_pos, 8'h00));
      run_col  = '0;
      col_pos  = '0;
      line_pos = '0;
    end else if (c == cst_pkg::CH_SPACE) begin
      col_pos = bump(col_pos);
    end else if (is_alpha(c) || is_digit(c)) begin
      scan_mode = is_alpha(c) ? cst_pkg::MODE_IDENT : cst_pkg::MODE_NUM;
      run_col   = col_pos;
      col_pos   = bump(col_pos);
    end else if (c == cst_pkg::CH_NEWLINE) begin
      toks.push_back(make_token(cst_pkg::K_EOL, col_pos, bump(col_pos), c));
      col_pos  = '0;
      line_pos = bump(line_pos);
    end else begin
      toks.push_back(make_token(single_kind(c), col_pos, bump(col_pos), c));
      col_pos = bump(col_pos);
    end
    if (toks.size() != 0)
      toks[toks.size() - 1].last = 1'b1;
    foreach (toks[i])
      expected_tokens.push_back(toks[i]);
  endfunction

  task automatic report_error(input string what, input longint got, input longint want);
    err_count++;
    if (err_count <= 40)
      $display("ERROR at %0t: token %0d, %s: got %0d, expected %0d",
               $time, tokens_seen, what, got, want);
  endtask

  // Offers one input and holds it until the transfer completes.
  task automatic send_item(input logic func, input logic [7:0] c);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    predict_tokens(func, c);
    chars_sent++;
  endtask

  // Stops offering input, waits for every predicted token and then goes on
  // waiting so that a stray token would still be caught.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver: a random stall before each transfer while idling, or a long hold on request.
  initial begin : token_sink
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req != 0) begin
        gap      = hold_req;
        hold_req = 0;
      end else begin
        gap = idle_on ? $urandom_range(0, 9) : 0;
      end
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin : check_tokens
    cst_pkg::token_t want;
    if (!rst && m_tvalid && m_tready) begin
      tokens_seen++;
      if (expected_tokens.size() == 0) begin
        report_error("token with none predicted, kind", m_tdata[3:0], 0);
      end else begin
        want = expected_tokens.pop_front();
        if (m_tdata[3:0] != want.token_kind)
          report_error("token_kind", m_tdata[3:0], want.token_kind);
        if (m_tdata[19:4] != want.start_col)
          report_error("start_col", m_tdata[19:4], want.start_col);
        if (m_tdata[35:20] != want.end_col)
          report_error("end_col", m_tdata[35:20], want.end_col);
        if (m_tdata[51:36] != want.line_num)
          report_error("line_num", m_tdata[51:36], want.line_num);
        if (m_tdata[59:52] != want.token_char)
          report_error("token_char", m_tdata[59:52], want.token_char);
        if (m_tdata[63:60] != 4'h0)
          report_error("padding", m_tdata[63:60], 0);
        if (m_tlast != want.last)
          report_error("tlast", m_tlast, want.last);
      end
    end
  end

  // Every token kind, a letter run cut by a digit, a digit run cut by a
  // one-character token, zero and all-ones bytes, and trailing spaces.
  task automatic test_token_kinds();
    string text;
    text = "aZ90()+-*/=";
    foreach (text[i])
      send_item(cst_pkg::FUNC_CHAR, text[i]);
    send_item(cst_pkg::FUNC_CHAR, cst_pkg::CH_NEWLINE);
    send_item(cst_pkg::FUNC_CHAR, 8'h00);
    send_item(cst_pkg::FUNC_CHAR, 8'hFF);
    send_item(cst_pkg::FUNC_CHAR, "z");
    send_item(cst_pkg::FUNC_CHAR, cst_pkg::CH_SPACE);
    send_item(cst_pkg::FUNC_CHAR, cst_pkg::CH_SPACE);
    send_item(cst_pkg::FUNC_EOT, 8'hA5);
    wait_drained();
  endtask

  // End of text with a pending number, a pending identifier, and no text.
  task automatic test_eot_cuts_runs();
    send_item(cst_pkg::FUNC_CHAR, "7");
    send_item(cst_pkg::FUNC_EOT, 8'h5A);
    send_item(cst_pkg::FUNC_CHAR, "q");
    send_item(cst_pkg::FUNC_EOT, 8'h00);
    send_item(cst_pkg::FUNC_EOT, 8'hFF);
    wait_drained();
  endtask

  // The receiver holds off while inputs keep coming, so the token queue fills
  // and the slave side must stall.
  task automatic test_output_stall();
    idle_on  = 1'b0;
    hold_req = 300;
    repeat (20) begin
      send_item(cst_pkg::FUNC_CHAR, "a");
      send_item(cst_pkg::FUNC_CHAR, cst_pkg::CH_PLUS);
    end
    send_item(cst_pkg::FUNC_EOT, 8'h00);
    wait_drained();
    idle_on = 1'b1;
  endtask

  // Random texts built from words, numbers, operators, spaces and newlines,
  // with some arbitrary bytes mixed in; each text ends with end of text.
  task automatic test_random_text(input int n_items);
    logic [7:0] ops[7] = '{cst_pkg::CH_LPAREN, cst_pkg::CH_RPAREN, cst_pkg::CH_PLUS,
                           cst_pkg::CH_MINUS, cst_pkg::CH_STAR, cst_pkg::CH_SLASH,
                           cst_pkg::CH_EQUAL};
    int         stop_at;
    int         pick;
    stop_at = chars_sent + n_items;
    while (chars_sent < stop_at) begin
      // Some texts run with no idling on either side.
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 12)) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          repeat ($urandom_range(1, 8))
            send_item(cst_pkg::FUNC_CHAR,
                      $urandom_range(0, 1) ? 8'("A" + $urandom_range(0, 25))
                                           : 8'("a" + $urandom_range(0, 25)));
        end else if (pick < 50) begin
          repeat ($urandom_range(1, 5))
            send_item(cst_pkg::FUNC_CHAR, 8'("0" + $urandom_range(0, 9)));
        end else if (pick < 65) begin
          send_item(cst_pkg::FUNC_CHAR, ops[$urandom_range(0, 6)]);
        end else if (pick < 77) begin
          repeat ($urandom_range(1, 3)) send_item(cst_pkg::FUNC_CHAR, cst_pkg::CH_SPACE);
        end else if (pick < 85) begin
          send_item(cst_pkg::FUNC_CHAR, cst_pkg::CH_NEWLINE);
        end else begin
          send_item(cst_pkg::FUNC_CHAR, 8'($urandom_range(0, 255)));
        end
      end
      send_item(cst_pkg::FUNC_EOT, 8'($urandom));
    end
    wait_drained();
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_token_kinds();
    test_eot_cuts_runs();
    test_output_stall();
    test_random_text(880);
    $display("Sent %0d input transfers and checked %0d tokens.", chars_sent, tokens_seen);
    $display("Covered all token kinds, runs cut by end of text, a long output stall "
             , "and random texts with random idling on both sides.");
    if (err_count == 0 && expected_tokens.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d tokens still predicted", expected_tokens.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
